// ===== src/qypr_pkg.sv =====
`timescale 1ns / 1ps

package qypr_pkg;

  localparam int Q_W   = 32;
  localparam int G_W   = 32;
  localparam int A_W   = 37;
  localparam int ANG_W = 16;
  localparam int S_W   = 64;
  localparam int R_W   = 32;

  localparam int CW           = 45;
  localparam int ZW           = 28;
  localparam int NW           = 41;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 24;
  localparam int RND_SH       = 11;

  localparam int ISQ_LAT  = S_W / 2;
  localparam int ATAN_LAT = 1 + NORM_STEPS + CORDIC_STEPS + 1;
  localparam int BACK_LAT = 2 + ISQ_LAT + ATAN_LAT;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic signed [ZW-1:0]    HALF_PI_FINE = 28'sd26353589;
  localparam logic signed [ANG_W-1:0] HALF_PI_OUT  = 16'sd12868;
  localparam logic signed [ANG_W-1:0] PI_OUT       = 16'sd25736;

  typedef struct packed {
    logic                  has_q;
    logic signed [G_W-1:0] gx;
    logic signed [G_W-1:0] gy;
    logic signed [G_W-1:0] gz;
    logic signed [A_W-1:0] yn;
    logic signed [A_W-1:0] yd;
  } item_t;

  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 28'sd13176795;
      1: r = 28'sd7778716;
      2: r = 28'sd4110060;
      3: r = 28'sd2086331;
      4: r = 28'sd1047214;
      5: r = 28'sd524117;
      6: r = 28'sd262123;
      7: r = 28'sd131069;
      default: r = ZW'(1) <<< (CORDIC_STEPS - i);
    endcase
    return r;
  endfunction

endpackage

// ===== src/quaternion_to_yaw_pitch_roll_top.sv =====
`timescale 1ns / 1ps
// Channel | Handshake               | Payload
// in      | in_valid_i / in_ready_o | q_w_i q_x_i q_y_i q_z_i has_quaternion_i
// out     | out_valid_o/out_ready_i | yaw_o pitch_o roll_o gravity_x_o gravity_y_o
//         |                         | gravity_z_o angles_valid_o
//
// One transfer per cycle sustained while out_ready_i is high.
// Front: input, product, sum and gravity stages; back: squares, sum, a 32-stage
// square root and a 32-stage CORDIC atan2 (normalize, 24 rotations, round).
// Reset clears the valid bits, queue pointers and queue count only.
// out_ready_i low with a result waiting freezes the back; the 4-entry queue absorbs the front,
// and in_ready_o drops only when the queue is full.

module quaternion_to_yaw_pitch_roll_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [qypr_pkg::Q_W-1:0]   q_w_i,
  input  logic signed [qypr_pkg::Q_W-1:0]   q_x_i,
  input  logic signed [qypr_pkg::Q_W-1:0]   q_y_i,
  input  logic signed [qypr_pkg::Q_W-1:0]   q_z_i,
  input  logic                              has_quaternion_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [qypr_pkg::ANG_W-1:0] yaw_o,
  output logic signed [qypr_pkg::ANG_W-1:0] pitch_o,
  output logic signed [qypr_pkg::ANG_W-1:0] roll_o,
  output logic signed [qypr_pkg::G_W-1:0]   gravity_x_o,
  output logic signed [qypr_pkg::G_W-1:0]   gravity_y_o,
  output logic signed [qypr_pkg::G_W-1:0]   gravity_z_o,
  output logic                              angles_valid_o
);
  import qypr_pkg::*;

  logic  push, full, pop, q_valid;
  item_t f_item, q_item;

  qypr_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .q_w_i(q_w_i), .q_x_i(q_x_i), .q_y_i(q_y_i), .q_z_i(q_z_i),
    .has_quaternion_i(has_quaternion_i),
    .full_i(full), .push_o(push), .item_o(f_item)
  );

  qypr_fifo u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(push), .data_i(f_item), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_item)
  );

  qypr_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .valid_i(q_valid), .item_i(q_item), .pop_o(pop),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .yaw_o(yaw_o), .pitch_o(pitch_o), .roll_o(roll_o),
    .gravity_x_o(gravity_x_o), .gravity_y_o(gravity_y_o), .gravity_z_o(gravity_z_o),
    .angles_valid_o(angles_valid_o)
  );

endmodule

// ===== src/qypr_front.sv =====
`timescale 1ns / 1ps

module qypr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [qypr_pkg::Q_W-1:0] q_w_i,
  input  logic signed [qypr_pkg::Q_W-1:0] q_x_i,
  input  logic signed [qypr_pkg::Q_W-1:0] q_y_i,
  input  logic signed [qypr_pkg::Q_W-1:0] q_z_i,
  input  logic                          has_quaternion_i,
  input  logic                          full_i,
  output logic                          push_o,
  output qypr_pkg::item_t               item_o
);
  import qypr_pkg::*;

  function automatic logic signed [G_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [G_W-1:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = $signed(v[G_W-1:0]);
    return r;
  endfunction

  logic       en;
  logic [3:0] vld_q;

  logic signed [Q_W-1:0] w_q, x_q, y_q, z_q;
  logic                  ha_q, hb_q, hc_q;

  logic signed [63:0] p_xz_q, p_wy_q, p_wx_q, p_yz_q, p_ww_q;
  logic signed [63:0] p_xx_q, p_yy_q, p_zz_q, p_xy_q, p_wz_q;

  logic signed [64:0] gx_s_q, gy_s_q, gz_a_q, gz_b_q, yn_s_q, yd_s_q;

  logic signed [65:0] gz_s;
  item_t              item_d, item_q;

  assign en         = !full_i;
  assign in_ready_o = en;
  assign push_o     = en && vld_q[3];
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q  <= q_w_i;
      x_q  <= q_x_i;
      y_q  <= q_y_i;
      z_q  <= q_z_i;
      ha_q <= has_quaternion_i;

      p_xz_q <= 64'(x_q) * 64'(z_q);
      p_wy_q <= 64'(w_q) * 64'(y_q);
      p_wx_q <= 64'(w_q) * 64'(x_q);
      p_yz_q <= 64'(y_q) * 64'(z_q);
      p_ww_q <= 64'(w_q) * 64'(w_q);
      p_xx_q <= 64'(x_q) * 64'(x_q);
      p_yy_q <= 64'(y_q) * 64'(y_q);
      p_zz_q <= 64'(z_q) * 64'(z_q);
      p_xy_q <= 64'(x_q) * 64'(y_q);
      p_wz_q <= 64'(w_q) * 64'(z_q);
      hb_q   <= ha_q;

      gx_s_q <= 65'(p_xz_q) - 65'(p_wy_q);
      gy_s_q <= 65'(p_wx_q) + 65'(p_yz_q);
      gz_a_q <= 65'(p_ww_q) + 65'(p_zz_q);
      gz_b_q <= 65'(p_xx_q) + 65'(p_yy_q);
      yn_s_q <= 65'(p_xy_q) - 65'(p_wz_q);
      yd_s_q <= 65'(p_ww_q) + 65'(p_xx_q);
      hc_q   <= hb_q;

      item_q <= item_d;
    end
  end

  assign gz_s = 66'(gz_a_q) - 66'(gz_b_q);

  always_comb begin
    item_d = '0;
    if (hc_q) begin
      item_d.has_q = 1'b1;
      item_d.gx    = sat32(66'(gx_s_q >>> 29));
      item_d.gy    = sat32(66'(gy_s_q >>> 29));
      item_d.gz    = sat32(gz_s >>> 30);
      item_d.yn    = A_W'(yn_s_q >>> 29);
      item_d.yd    = A_W'((yd_s_q >>> 29) - 65'sd1073741824);
    end
  end

endmodule

// ===== src/qypr_fifo.sv =====
`timescale 1ns / 1ps

module qypr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qypr_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output qypr_pkg::item_t data_o
);
  import qypr_pkg::*;

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i) rd_q <= rd_q + QPTR_W'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + QCNT_W'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

  a_keep_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !pop_i |=> valid_o) else $error("queued item lost");

endmodule

// ===== src/qypr_isqrt.sv =====
`timescale 1ns / 1ps

module qypr_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [qypr_pkg::S_W-1:0]   s_i,
  output logic [qypr_pkg::R_W-1:0]   root_o
);
  import qypr_pkg::*;

  logic [S_W-1:0] v_in [ISQ_LAT];
  logic [S_W-1:0] r_in [ISQ_LAT];
  logic [S_W-1:0] v_q  [ISQ_LAT-1];
  logic [S_W-1:0] r_q  [ISQ_LAT];

  for (genvar j = 0; j < ISQ_LAT; j++) begin : g_stage
    localparam logic [S_W-1:0] BIT = S_W'(1) << (S_W - 2 - 2 * j);
    logic [S_W-1:0] trial;
    logic           ge;

    if (j == 0) begin : g_first
      assign v_in[j] = s_i;
      assign r_in[j] = '0;
    end else begin : g_next
      assign v_in[j] = v_q[j-1];
      assign r_in[j] = r_q[j-1];
    end

    assign trial = r_in[j] + BIT;
    assign ge    = v_in[j] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j] <= ge ? (r_in[j] >> 1) + BIT : r_in[j] >> 1;
      end
    end

    if (j < ISQ_LAT - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q[j] <= ge ? v_in[j] - trial : v_in[j];
        end
      end
    end
  end

  assign root_o = r_q[ISQ_LAT-1][R_W-1:0];

endmodule

// ===== src/qypr_atan.sv =====
`timescale 1ns / 1ps

module qypr_atan (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [qypr_pkg::A_W-1:0]    num_i,
  input  logic signed [qypr_pkg::A_W-1:0]    den_i,
  output logic signed [qypr_pkg::ANG_W-1:0]  ang_o
);
  import qypr_pkg::*;

  localparam int LAST = NORM_STEPS + CORDIC_STEPS;
  localparam logic signed [ZW-1:0] ZANG_MAX = ZW'(32767);
  localparam logic signed [ZW-1:0] ZANG_MIN = -ZW'(32768);

  logic signed [CW-1:0]    n0, d0;
  logic signed [CW-1:0]    n_d, d_d;
  logic signed [ZW-1:0]    z_d;
  logic [NW-1:0]           an, ad, m_d;
  logic                    sp_d;
  logic signed [ANG_W-1:0] spv_d;

  logic signed [CW-1:0]    n_q   [LAST];
  logic signed [CW-1:0]    d_q   [LAST];
  logic signed [ZW-1:0]    z_q   [LAST+1];
  logic [NW-1:0]           m_q   [NORM_STEPS];
  logic                    sp_q  [LAST+1];
  logic signed [ANG_W-1:0] spv_q [LAST+1];

  logic signed [ZW-1:0]    zr, r;
  logic signed [ANG_W-1:0] ang_d, ang_q;

  assign n0 = CW'(num_i);
  assign d0 = CW'(den_i);

  always_comb begin
    sp_d  = 1'b0;
    spv_d = '0;
    if (d0 == '0) begin
      sp_d = 1'b1;
      if (n0[CW-1]) spv_d = -HALF_PI_OUT;
      else if (n0 != '0) spv_d = HALF_PI_OUT;
    end else if (n0 == '0) begin
      sp_d  = 1'b1;
      spv_d = d0[CW-1] ? PI_OUT : '0;
    end
    n_d = n0;
    d_d = d0;
    z_d = '0;
    if (d0[CW-1]) begin
      if (!n0[CW-1]) begin
        n_d = -d0;
        d_d = n0;
        z_d = HALF_PI_FINE;
      end else begin
        n_d = d0;
        d_d = -n0;
        z_d = -HALF_PI_FINE;
      end
    end
    an  = n0[CW-1] ? NW'(-n0) : NW'(n0);
    ad  = d0[CW-1] ? NW'(-d0) : NW'(d0);
    m_d = (an > ad) ? an : ad;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= n_d;
      d_q[0]   <= d_d;
      z_q[0]   <= z_d;
      m_q[0]   <= m_d;
      sp_q[0]  <= sp_d;
      spv_q[0] <= spv_d;
    end
  end

  for (genvar s = 1; s <= NORM_STEPS; s++) begin : g_norm
    localparam int SH = 1 << (NORM_STEPS - s);
    logic shift;
    assign shift = (m_q[s-1] >> (NW - SH)) == '0;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s]   <= shift ? n_q[s-1] <<< SH : n_q[s-1];
        d_q[s]   <= shift ? d_q[s-1] <<< SH : d_q[s-1];
        z_q[s]   <= z_q[s-1];
        sp_q[s]  <= sp_q[s-1];
        spv_q[s] <= spv_q[s-1];
      end
    end

    if (s < NORM_STEPS) begin : g_mag
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          m_q[s] <= shift ? m_q[s-1] << SH : m_q[s-1];
        end
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam int K = NORM_STEPS + i;
    localparam logic signed [ZW-1:0] STEP = atan_step(i);
    logic neg;
    assign neg = n_q[K][CW-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[K+1]   <= neg ? z_q[K] - STEP : z_q[K] + STEP;
        sp_q[K+1]  <= sp_q[K];
        spv_q[K+1] <= spv_q[K];
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_vec
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!neg) begin
            d_q[K+1] <= d_q[K] + (n_q[K] >>> i);
            n_q[K+1] <= n_q[K] - (d_q[K] >>> i);
          end else begin
            d_q[K+1] <= d_q[K] - (n_q[K] >>> i);
            n_q[K+1] <= n_q[K] + (d_q[K] >>> i);
          end
        end
      end
    end
  end

  assign zr = z_q[LAST] + ZW'(1024);
  assign r  = zr >>> RND_SH;

  always_comb begin
    if (sp_q[LAST]) ang_d = spv_q[LAST];
    else if (r > ZANG_MAX) ang_d = 16'sh7FFF;
    else if (r < ZANG_MIN) ang_d = 16'sh8000;
    else ang_d = $signed(r[ANG_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
    end
  end

  assign ang_o = ang_q;

endmodule

// ===== src/qypr_back.sv =====
`timescale 1ns / 1ps

module qypr_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  qypr_pkg::item_t                   item_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [qypr_pkg::ANG_W-1:0] yaw_o,
  output logic signed [qypr_pkg::ANG_W-1:0] pitch_o,
  output logic signed [qypr_pkg::ANG_W-1:0] roll_o,
  output logic signed [qypr_pkg::G_W-1:0]   gravity_x_o,
  output logic signed [qypr_pkg::G_W-1:0]   gravity_y_o,
  output logic signed [qypr_pkg::G_W-1:0]   gravity_z_o,
  output logic                              angles_valid_o
);
  import qypr_pkg::*;

  localparam int L     = BACK_LAT;
  localparam int A_IDX = 1 + ISQ_LAT;

  typedef struct packed {
    logic                  has_q;
    logic signed [G_W-1:0] gx;
    logic signed [G_W-1:0] gy;
    logic signed [G_W-1:0] gz;
  } grav_t;

  typedef struct packed {
    logic signed [A_W-1:0] yn;
    logic signed [A_W-1:0] yd;
  } yarg_t;

  logic           en;
  logic [L-1:0]   vld_q;
  grav_t          dly_q [L];
  yarg_t          ydl_q [A_IDX+1];
  logic [S_W-1:0] sq_x_q, sq_y_q, sq_z_q;
  logic [S_W-1:0] s_p_q, s_r_q;
  logic [R_W-1:0] rt_p, rt_r;

  logic signed [ANG_W-1:0] yaw_a, pitch_a, roll_a;
  grav_t                   g_out;

  assign en          = !vld_q[L-1] || out_ready_i;
  assign pop_o       = en && valid_i;
  assign out_valid_o = vld_q[L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= '{has_q: item_i.has_q, gx: item_i.gx, gy: item_i.gy, gz: item_i.gz};
      for (int k = 1; k < L; k++) dly_q[k] <= dly_q[k-1];
      ydl_q[0] <= '{yn: item_i.yn, yd: item_i.yd};
      for (int k = 1; k <= A_IDX; k++) ydl_q[k] <= ydl_q[k-1];

      sq_x_q <= S_W'(64'(item_i.gx) * 64'(item_i.gx));
      sq_y_q <= S_W'(64'(item_i.gy) * 64'(item_i.gy));
      sq_z_q <= S_W'(64'(item_i.gz) * 64'(item_i.gz));
      s_p_q  <= sq_y_q + sq_z_q;
      s_r_q  <= sq_x_q + sq_z_q;
    end
  end

  qypr_isqrt u_isqrt_p (.clk_i(clk_i), .en_i(en), .s_i(s_p_q), .root_o(rt_p));
  qypr_isqrt u_isqrt_r (.clk_i(clk_i), .en_i(en), .s_i(s_r_q), .root_o(rt_r));

  qypr_atan u_atan_yaw (
    .clk_i(clk_i), .en_i(en),
    .num_i(ydl_q[A_IDX].yn), .den_i(ydl_q[A_IDX].yd), .ang_o(yaw_a)
  );

  qypr_atan u_atan_pitch (
    .clk_i(clk_i), .en_i(en),
    .num_i(A_W'(dly_q[A_IDX].gx)),
    .den_i($signed({{(A_W - R_W){1'b0}}, rt_p})),
    .ang_o(pitch_a)
  );

  qypr_atan u_atan_roll (
    .clk_i(clk_i), .en_i(en),
    .num_i(A_W'(dly_q[A_IDX].gy)),
    .den_i($signed({{(A_W - R_W){1'b0}}, rt_r})),
    .ang_o(roll_a)
  );

  assign g_out          = dly_q[L-1];
  assign angles_valid_o = g_out.has_q;
  assign gravity_x_o    = g_out.gx;
  assign gravity_y_o    = g_out.gy;
  assign gravity_z_o    = g_out.gz;
  assign yaw_o          = g_out.has_q ? yaw_a : '0;
  assign pitch_o        = g_out.has_q ? pitch_a : '0;
  assign roll_o         = g_out.has_q ? roll_a : '0;

endmodule

// ===== bench/quaternion_to_yaw_pitch_roll_top_tb.sv =====
`timescale 1ns / 1ps

module quaternion_to_yaw_pitch_roll_top_tb;
  import qypr_pkg::*;

  typedef struct {
    logic signed [Q_W-1:0] w, x, y, z;
    logic                  has_q;
  } quat_t;

  typedef struct {
    logic signed [ANG_W-1:0] yaw, pitch, roll;
    logic signed [G_W-1:0]   gx, gy, gz;
    logic                    valid;
  } angles_t;

  localparam int LATENCY = 70;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [Q_W-1:0] q_w_i, q_x_i, q_y_i, q_z_i;
  logic has_quaternion_i;
  logic signed [ANG_W-1:0] yaw_o, pitch_o, roll_o;
  logic signed [G_W-1:0] gravity_x_o, gravity_y_o, gravity_z_o;
  logic angles_valid_o;

  quat_t   pending_quats[$];
  angles_t expected_angles[$];
  int      errors;
  int      stall_hold;
  int      pause_hold;
  bit      stim_done;
  int      sent, received;

  quaternion_to_yaw_pitch_roll_top u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint floor_div(logic signed [65:0] v, int sh);
    logic signed [65:0] t;
    t = v >>> sh;
    return longint'(t);
  endfunction

  function automatic longint sat_g(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [ANG_W-1:0] cordic_atan2(longint n, longint d);
    longint ang, t, dn, dd, stp, r;
    longint unsigned an, ad, m;
    ang = 0;
    if (d == 0) return n > 0 ? HALF_PI_OUT : (n < 0 ? -HALF_PI_OUT : 16'sd0);
    if (n == 0) return d > 0 ? 16'sd0 : PI_OUT;
    if (d < 0) begin
      t = d;
      if (n > 0) begin
        d = n; n = -t; ang = 26353589;
      end else begin
        d = -n; n = t; ang = -26353589;
      end
    end
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    m  = an > ad ? an : ad;
    while (m < (64'd1 << 40)) begin
      m <<= 1; n = n * 2; d = d * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      stp = longint'(atan_step(i));
      dn  = n >>> i;
      dd  = d >>> i;
      if (n >= 0) begin
        d = d + dn; n = n - dd; ang = ang + stp;
      end else begin
        d = d - dn; n = n + dd; ang = ang - stp;
      end
    end
    r = (ang + 1024) >>> 11;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[ANG_W-1:0];
  endfunction

  function automatic angles_t predict_angles(quat_t q);
    angles_t a;
    logic signed [65:0] w, x, y, z;
    longint gx, gy, gz, yn, yd;
    longint unsigned s;
    a = '{default: 0};
    if (!q.has_q) return a;
    w  = q.w; x = q.x; y = q.y; z = q.z;
    gx = sat_g(floor_div(x * z - w * y, 29));
    gy = sat_g(floor_div(w * x + y * z, 29));
    gz = sat_g(floor_div(w * w - x * x - y * y + z * z, 30));
    yn = floor_div(x * y - w * z, 29);
    yd = floor_div(w * w + x * x, 29) - (64'sd1 <<< 30);
    a.yaw = cordic_atan2(yn, yd);
    s = longint'(gy * gy) + longint'(gz * gz);
    a.pitch = cordic_atan2(gx, int_sqrt(s));
    s = longint'(gx * gx) + longint'(gz * gz);
    a.roll = cordic_atan2(gy, int_sqrt(s));
    a.gx = gx[31:0]; a.gy = gy[31:0]; a.gz = gz[31:0];
    a.valid = 1'b1;
    return a;
  endfunction

  function automatic logic signed [31:0] rand_part();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h8000_0000) - 32'sh4000_0000;
      2: return {$urandom_range(0, 1) ? 2'b11 : 2'b00, 30'($urandom)};
      default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  task automatic push_quat(logic signed [31:0] w, x, y, z, logic h);
    quat_t q;
    q = '{w, x, y, z, h};
    pending_quats.push_back(q);
  endtask

  // Driver: random gap before each item, optional pause for drain.
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      {q_w_i, q_x_i, q_y_i, q_z_i, has_quaternion_i} <= '0;
      gap_left <= 0;
      sent <= 0;
      pause_hold <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_angles.push_back(predict_angles(pending_quats.pop_front()));
        sent <= sent + 1;
        if (sent == 500) pause_hold <= 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_quats.size() > 0
                     && !(pause_hold && expected_angles.size() > 0)) begin
          in_valid_i <= 1'b1;
          q_w_i <= pending_quats[0].w;
          q_x_i <= pending_quats[0].x;
          q_y_i <= pending_quats[0].y;
          q_z_i <= pending_quats[0].z;
          has_quaternion_i <= pending_quats[0].has_q;
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
          if (pause_hold) pause_hold <= 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transfer and draw the next stall.
  int stall_left;
  int wait_draw;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
      received <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        received <= received + 1;
        if (expected_angles.size() == 0) begin
          $error("unexpected result");
          errors++;
        end else begin
          angles_t e;
          e = expected_angles.pop_front();
          if (yaw_o !== e.yaw) begin
            $error("yaw exp %0d got %0d", e.yaw, yaw_o); errors++;
          end
          if (pitch_o !== e.pitch) begin
            $error("pitch exp %0d got %0d", e.pitch, pitch_o); errors++;
          end
          if (roll_o !== e.roll) begin
            $error("roll exp %0d got %0d", e.roll, roll_o); errors++;
          end
          if (gravity_x_o !== e.gx) begin
            $error("gravity_x exp %0d got %0d", e.gx, gravity_x_o); errors++;
          end
          if (gravity_y_o !== e.gy) begin
            $error("gravity_y exp %0d got %0d", e.gy, gravity_y_o); errors++;
          end
          if (gravity_z_o !== e.gz) begin
            $error("gravity_z exp %0d got %0d", e.gz, gravity_z_o); errors++;
          end
          if (angles_valid_o !== e.valid) begin
            $error("angles_valid exp %0d got %0d", e.valid, angles_valid_o); errors++;
          end
        end
      end
      if (stall_hold > 0) begin
        out_ready_i <= 1'b0;
        stall_hold <= stall_hold - 1;
      end else if (out_valid_o && out_ready_i) begin
        wait_draw = (sent > 700 && sent < 850) ? 0 : $urandom_range(0, 9);
        stall_left <= wait_draw;
        out_ready_i <= (wait_draw == 0);
      end else if (!out_ready_i) begin
        if (stall_left > 1) begin
          stall_left <= stall_left - 1;
        end else begin
          stall_left <= 0;
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  initial begin
    logic signed [31:0] ext[6];
    errors = 0;
    stall_hold = 0;
    stim_done = 0;
    rst_ni = 1'b0;
    ext = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh4000_0000, -32'sh4000_0000, 0, 1};
    push_quat(32'sh4000_0000, 0, 0, 0, 1);
    push_quat(0, 32'sh4000_0000, 0, 0, 1);
    push_quat(0, 0, 32'sh4000_0000, 0, 1);
    push_quat(0, 0, 0, 32'sh4000_0000, 1);
    push_quat(0, 0, 0, 0, 1);
    push_quat(32'sh2d41_3ccd, 0, 32'sh2d41_3ccd, 0, 1);
    push_quat(32'sh2d41_3ccd, 32'sh2d41_3ccd, 0, 0, 1);
    push_quat(32'sh2d41_3ccd, 0, 0, -32'sh2d41_3ccd, 1);
    push_quat($urandom, $urandom, $urandom, $urandom, 0);
    push_quat(-1, -1, -1, -1, 0);
    for (int i = 0; i < 6; i++)
      push_quat(ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6], ext[(i + 3) % 6], 1);
    for (int i = 0; i < 4; i++)
      push_quat(ext[i], ext[i], ext[i], ext[i], 1);
    for (int i = 0; i < 1030; i++)
      push_quat(rand_part(), rand_part(), rand_part(), rand_part(),
                $urandom_range(0, 7) != 0);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (sent >= 200);
    @(posedge clk_i);
    stall_hold <= 150;
    wait (pending_quats.size() == 0 && !in_valid_i);
    wait (expected_angles.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Checked %0d quaternions (%0d results), incl. extremes, absent samples,",
             sent, received);
    $display("long output stall and drained pause.");
    if (errors == 0 && expected_angles.size() == 0)
      $display("quaternion_to_yaw_pitch_roll_top: match");
    else
      $display("quaternion_to_yaw_pitch_roll_top: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("quaternion_to_yaw_pitch_roll_top: mismatch");
    $finish;
  end

endmodule
